FILE: sv/mspdf_pkg.sv
// Shared types and constants for the MSP v1 request-frame deframer.
// Used by the controller, the datapath and the top level; no dependencies.
package mspdf_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 64;
  localparam int unsigned STORE_CAP       = 64;  // limit set by the 6-bit byte_index

  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_M      = 8'h4D;  // 'M'
  localparam logic [7:0] CH_ARROW  = 8'h3C;  // '<'

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR_M,
    ST_HDR_ARROW,
    ST_SIZE,
    ST_CMD,
    ST_PAYLOAD,
    ST_CHECK,
    ST_RD,
    ST_LD
  } state_e;

  typedef struct packed {
    logic cap_size;
    logic cap_cmd;
    logic pay_byte;
    logic load_single;
    logic start_drain;
    logic rd_issue;
    logic load_pay;
  } dp_cmd_t;

  typedef struct packed {
    logic is_dollar;
    logic is_m;
    logic is_arrow;
    logic size_zero;
    logic pay_done;
    logic mismatch;
    logic out_free;
    logic drain_last;
  } dp_stat_t;

endpackage

FILE: sv/mspdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mspdf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/mspdf_ctrl.sv
// Frame parser controller: phase state machine issuing datapath commands.
// Depends on mspdf_pkg.
module mspdf_ctrl
  import mspdf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     rx_valid_i,
  output logic     rx_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    rx_stall_o = 1'b0;
    unique case (state_q)
      ST_CHECK:     rx_stall_o = !stat_i.out_free;
      ST_RD, ST_LD: rx_stall_o = 1'b1;
      default:      rx_stall_o = 1'b0;
    endcase
    accept = rx_valid_i && !rx_stall_o;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && stat_i.is_dollar) state_d = ST_HDR_M;
      end
      ST_HDR_M: begin
        if (accept) state_d = stat_i.is_m ? ST_HDR_ARROW : ST_IDLE;
      end
      ST_HDR_ARROW: begin
        if (accept) state_d = stat_i.is_arrow ? ST_SIZE : ST_IDLE;
      end
      ST_SIZE: begin
        if (accept) begin
          cmd_o.cap_size = 1'b1;
          state_d        = ST_CMD;
        end
      end
      ST_CMD: begin
        if (accept) begin
          cmd_o.cap_cmd = 1'b1;
          state_d       = stat_i.size_zero ? ST_CHECK : ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        if (accept) begin
          cmd_o.pay_byte = 1'b1;
          if (stat_i.pay_done) state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (accept) begin
          if (stat_i.mismatch || stat_i.size_zero) begin
            cmd_o.load_single = 1'b1;
            state_d           = ST_IDLE;
          end else begin
            cmd_o.start_drain = 1'b1;
            state_d           = ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_LD;
      end
      ST_LD: begin
        if (stat_i.out_free) begin
          cmd_o.load_pay = 1'b1;
          state_d        = stat_i.drain_last ? ST_IDLE : ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: sv/mspdf_dp.sv
// Frame parser datapath: header fields, checksum, payload store, result register.
// Depends on mspdf_pkg and mspdf_ram.
module mspdf_dp
  import mspdf_pkg::*;
#(
  parameter int unsigned STORE_LIMIT = STORE_CAP
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  dp_cmd_t    cmd_i,
  output dp_stat_t   stat_o,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic       frame_status_o,
  output logic [7:0] command_id_o,
  output logic [7:0] frame_size_o,
  output logic       has_payload_o,
  output logic [7:0] payload_byte_o,
  output logic [5:0] byte_index_o,
  output logic       truncated_o,
  output logic       last_result_o
);

  localparam int unsigned AW = (STORE_LIMIT > 1) ? $clog2(STORE_LIMIT) : 1;
  localparam logic [7:0]  LimitB    = 8'(STORE_LIMIT);
  localparam logic [5:0]  LimitLast = 6'(STORE_LIMIT - 1);

  logic [7:0] size_q, cmd_q, seen_q, xor_q;
  logic [5:0] idx_q;
  logic       trunc;
  logic [5:0] last_idx;
  logic [7:0] rdata;
  logic       store_we;

  logic       out_valid_q;
  logic       o_status_q, o_has_q, o_trunc_q, o_last_q;
  logic [7:0] o_cmd_q, o_size_q, o_data_q;
  logic [5:0] o_idx_q;

  assign trunc    = size_q > LimitB;
  assign last_idx = trunc ? LimitLast : 6'(size_q - 8'd1);
  assign store_we = cmd_i.pay_byte && (seen_q < LimitB);

  assign stat_o.is_dollar  = rx_byte_i == CH_DOLLAR;
  assign stat_o.is_m       = rx_byte_i == CH_M;
  assign stat_o.is_arrow   = rx_byte_i == CH_ARROW;
  assign stat_o.size_zero  = size_q == 8'd0;
  assign stat_o.pay_done   = ({1'b0, seen_q} + 9'd1) >= {1'b0, size_q};
  assign stat_o.mismatch   = rx_byte_i != xor_q;
  assign stat_o.out_free   = !out_valid_q || !res_stall_i;
  assign stat_o.drain_last = idx_q == last_idx;

  mspdf_ram #(
    .WIDTH(8),
    .DEPTH(STORE_LIMIT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (seen_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Frame registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
      cmd_q  <= '0;
      seen_q <= '0;
      xor_q  <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.cap_size) begin
        size_q <= rx_byte_i;
        xor_q  <= rx_byte_i;
        seen_q <= '0;
      end
      if (cmd_i.cap_cmd) begin
        cmd_q <= rx_byte_i;
        xor_q <= xor_q ^ rx_byte_i;
      end
      if (cmd_i.pay_byte) begin
        seen_q <= seen_q + 8'd1;
        xor_q  <= xor_q ^ rx_byte_i;
      end
      if (cmd_i.start_drain) begin
        idx_q <= '0;
      end else if (cmd_i.load_pay) begin
        idx_q <= idx_q + 6'd1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_single || cmd_i.load_pay) begin
      out_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_single || cmd_i.load_pay) begin
      o_cmd_q   <= cmd_q;
      o_size_q  <= size_q;
      o_trunc_q <= trunc;
    end
    if (cmd_i.load_single) begin
      o_status_q <= stat_o.mismatch;
      o_has_q    <= 1'b0;
      o_data_q   <= '0;
      o_idx_q    <= '0;
      o_last_q   <= 1'b1;
    end else if (cmd_i.load_pay) begin
      o_status_q <= 1'b0;
      o_has_q    <= 1'b1;
      o_data_q   <= rdata;
      o_idx_q    <= idx_q;
      o_last_q   <= stat_o.drain_last;
    end
  end

  assign res_valid_o    = out_valid_q;
  assign frame_status_o = o_status_q;
  assign command_id_o   = o_cmd_q;
  assign frame_size_o   = o_size_q;
  assign has_payload_o  = o_has_q;
  assign payload_byte_o = o_data_q;
  assign byte_index_o   = o_idx_q;
  assign truncated_o    = o_trunc_q;
  assign last_result_o  = o_last_q;

endmodule

FILE: sv/msp_v1_frame_deframer_top.sv
// MSP v1 request-frame deframer, top level.
// Depends on mspdf_pkg, mspdf_ctrl, mspdf_dp (which holds mspdf_ram).

// Takes one received byte per cycle while not stalled and parses '$' 'M' '<'
// size command payload checksum request frames. Header, size, command and
// payload bytes are accepted one a cycle. On the checksum byte the block emits
// either one result (checksum mismatch, or an empty frame) or one result per
// stored payload byte; in the latter case input is stalled while each stored
// byte is read from the payload RAM and then loaded into the result register,
// and while the result side stalls. At most min(MAX_PAYLOAD, 64) bytes are
// stored; longer frames are still checked to their declared end and flagged
// truncated. The payload RAM needs no clearing after reset.
module msp_v1_frame_deframer_top
  import mspdf_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic       frame_status_o,
  output logic [7:0] command_id_o,
  output logic [7:0] frame_size_o,
  output logic       has_payload_o,
  output logic [7:0] payload_byte_o,
  output logic [5:0] byte_index_o,
  output logic       truncated_o,
  output logic       last_result_o
);

  localparam int unsigned StoreLimit = (MAX_PAYLOAD < STORE_CAP) ? MAX_PAYLOAD : STORE_CAP;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mspdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mspdf_dp #(
    .STORE_LIMIT(StoreLimit)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .frame_status_o (frame_status_o),
    .command_id_o   (command_id_o),
    .frame_size_o   (frame_size_o),
    .has_payload_o  (has_payload_o),
    .payload_byte_o (payload_byte_o),
    .byte_index_o   (byte_index_o),
    .truncated_o    (truncated_o),
    .last_result_o  (last_result_o)
  );

endmodule

FILE: test/tb_msp_v1_frame_deframer_top.sv
// Self-checking testbench for msp_v1_frame_deframer_top: drives received bytes and
// checks every frame result against an in-bench frame predictor.
// Depends on mspdf_pkg and the deframer RTL.
module tb_msp_v1_frame_deframer_top;
  import mspdf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_LIM   = (MAX_PAYLOAD_DEF < STORE_CAP) ? MAX_PAYLOAD_DEF : STORE_CAP;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned MAX_PRINTS  = 50;
  localparam int unsigned ITEMS_TOTAL = 230;

  typedef struct packed {
    logic       status;
    logic [7:0] cmd;
    logic [7:0] size;
    logic       has;
    logic [7:0] data;
    logic [5:0] idx;
    logic       trunc;
    logic       last;
  } frame_res_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       rx_valid_i  = 1'b0;
  logic       rx_stall_o;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       res_valid_o;
  logic       res_stall_i = 1'b0;
  logic       frame_status_o;
  logic [7:0] command_id_o;
  logic [7:0] frame_size_o;
  logic       has_payload_o;
  logic [7:0] payload_byte_o;
  logic [5:0] byte_index_o;
  logic       truncated_o;
  logic       last_result_o;

  // frame predictor state
  state_e     pr_phase = ST_IDLE;
  logic [7:0] pr_size  = '0;
  logic [7:0] pr_cmd   = '0;
  logic [7:0] pr_seen  = '0;
  logic [7:0] pr_xor   = '0;
  logic [7:0] pr_store [64];

  frame_res_t  frame_res_q[$];
  int unsigned err_count   = 0;
  int unsigned bytes_sent  = 0;
  int unsigned idle_cycles = 0;
  bit          gaps_on     = 1'b1;

  msp_v1_frame_deframer_top #(
    .MAX_PAYLOAD(MAX_PAYLOAD_DEF)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_valid_i     (rx_valid_i),
    .rx_stall_o     (rx_stall_o),
    .rx_byte_i      (rx_byte_i),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .frame_status_o (frame_status_o),
    .command_id_o   (command_id_o),
    .frame_size_o   (frame_size_o),
    .has_payload_o  (has_payload_o),
    .payload_byte_o (payload_byte_o),
    .byte_index_o   (byte_index_o),
    .truncated_o    (truncated_o),
    .last_result_o  (last_result_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) begin
      $display("tb: mismatch at %0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  task automatic push_frame_res(input logic status, input logic has, input logic [7:0] data,
                                input logic [5:0] idx, input logic trunc, input logic last);
    frame_res_t r;
    r.status = status;
    r.cmd    = pr_cmd;
    r.size   = pr_size;
    r.has    = has;
    r.data   = data;
    r.idx    = idx;
    r.trunc  = trunc;
    r.last   = last;
    frame_res_q.push_back(r);
  endtask

  // advance the frame predictor by one accepted byte
  task automatic predict_byte(input logic [7:0] b);
    logic        trunc;
    int unsigned cnt;
    case (pr_phase)
      ST_HDR_M: begin
        pr_phase = (b == CH_M) ? ST_HDR_ARROW : ST_IDLE;
      end
      ST_HDR_ARROW: begin
        if (b == CH_ARROW) begin
          pr_xor   = '0;
          pr_phase = ST_SIZE;
        end else begin
          pr_phase = ST_IDLE;
        end
      end
      ST_SIZE: begin
        pr_size  = b;
        pr_xor   = b;
        pr_seen  = '0;
        pr_phase = ST_CMD;
      end
      ST_CMD: begin
        pr_cmd   = b;
        pr_xor   = pr_xor ^ b;
        pr_phase = (pr_size != 0) ? ST_PAYLOAD : ST_CHECK;
      end
      ST_PAYLOAD: begin
        if (pr_seen < STORE_LIM) pr_store[pr_seen[5:0]] = b;
        pr_seen = pr_seen + 8'd1;
        pr_xor  = pr_xor ^ b;
        if (pr_seen >= pr_size) pr_phase = ST_CHECK;
      end
      ST_CHECK: begin
        trunc = (pr_size > STORE_LIM);
        if (b != pr_xor) begin
          push_frame_res(1'b1, 1'b0, 8'h00, 6'd0, trunc, 1'b1);
        end else if (pr_size == 0) begin
          push_frame_res(1'b0, 1'b0, 8'h00, 6'd0, trunc, 1'b1);
        end else begin
          cnt = trunc ? STORE_LIM : pr_size;
          for (int unsigned i = 0; i < cnt; i++) begin
            push_frame_res(1'b0, 1'b1, pr_store[i[5:0]], i[5:0], trunc, (i + 1 == cnt));
          end
        end
        pr_phase = ST_IDLE;
      end
      default: begin
        pr_phase = (b == CH_DOLLAR) ? ST_HDR_M : ST_IDLE;
      end
    endcase
  endtask

  // leaves rx_valid_i high on return; the caller drops it through stop_rx
  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      rx_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (rx_stall_o !== 1'b0);
    bytes_sent++;
    predict_byte(b);
  endtask

  task automatic stop_rx();
    rx_valid_i <= 1'b0;
  endtask

  // waits on the clock before each check of the queue, so a following send never re-drives valid in the same step
  task automatic wait_drained();
    do @(posedge clk_i); while (frame_res_q.size() != 0);
  endtask

  task automatic send_frame(input logic [7:0] size, input logic [7:0] cmd, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] d;
    send_byte(CH_DOLLAR);
    send_byte(CH_M);
    send_byte(CH_ARROW);
    send_byte(size);
    send_byte(cmd);
    sum = size ^ cmd;
    for (int unsigned i = 0; i < size; i++) begin
      d   = 8'($urandom);
      sum = sum ^ d;
      send_byte(d);
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  task automatic test_empty_frames();
    send_frame(8'd0, 8'h00, 1'b0);
    send_frame(8'd0, 8'hFF, 1'b1);
  endtask

  task automatic test_header_errors();
    send_byte(8'hA5);            // idle noise
    send_byte(CH_DOLLAR);
    send_byte(8'h00);            // 'M' expected
    send_byte(CH_DOLLAR);
    send_byte(CH_M);
    send_byte(8'hFF);            // '<' expected
  endtask

  task automatic test_payload_extremes();
    logic [7:0] cmd;
    cmd = 8'h6C;
    send_byte(CH_DOLLAR);
    send_byte(CH_M);
    send_byte(CH_ARROW);
    send_byte(8'd2);
    send_byte(cmd);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'd2 ^ cmd ^ 8'hFF);
  endtask

  // exactly full store, then one byte over it
  task automatic test_store_limit();
    send_frame(8'(STORE_LIM), 8'($urandom), 1'b0);
    send_frame(8'(STORE_LIM + 1), 8'($urandom), 1'b0);
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned pick;
    bit          paused;
    logic [7:0]  size;
    goal   = ITEMS_TOTAL;
    paused = 1'b0;
    while (bytes_sent < goal) begin
      if (!paused && bytes_sent > goal - 50) begin
        // sender holds off until the block has drained everything
        stop_rx();
        wait_drained();
        paused = 1'b1;
      end
      if (bytes_sent > goal - 25) gaps_on = 1'b0;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_byte(8'($urandom));
      end else if (pick == 1) begin
        send_byte(CH_DOLLAR);
        if ($urandom_range(0, 1)) send_byte(CH_M);
        send_byte(8'($urandom));
      end else begin
        size = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 70))
                                            : 8'($urandom_range(0, 6));
        send_frame(size, 8'($urandom), $urandom_range(0, 6) == 0);
      end
    end
  endtask

  // result side: random stall bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) stall_left--;
      else if (gaps_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 12);
      res_stall_i <= (stall_left != 0);
    end
  end

  // result checker
  initial begin
    frame_res_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_valid_o === 1'b1 && res_stall_i === 1'b0) begin
        if (frame_res_q.size() == 0) begin
          report_mismatch("result with no item expected");
        end else begin
          want = frame_res_q.pop_front();
          check_field("frame_status", 8'(frame_status_o), 8'(want.status));
          check_field("command_id", command_id_o, want.cmd);
          check_field("frame_size", frame_size_o, want.size);
          check_field("has_payload", 8'(has_payload_o), 8'(want.has));
          check_field("payload_byte", payload_byte_o, want.data);
          check_field("byte_index", 8'(byte_index_o), 8'(want.idx));
          check_field("truncated", 8'(truncated_o), 8'(want.trunc));
          check_field("last_result", 8'(last_result_o), 8'(want.last));
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (rx_valid_i && !rx_stall_o) || (res_valid_o && !res_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_frames();
    test_header_errors();
    test_payload_extremes();
    test_store_limit();
    test_random_traffic();
    stop_rx();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
